// File: hw/rtl/nce_pkg.sv
package nce_pkg;

  localparam int unsigned NibW = 4;
  localparam int unsigned PcW  = 8;
  localparam int unsigned OpW  = 3;
  localparam int unsigned NumRegs = 4;

  // Instruction codes carried in the opcode field.
  typedef enum logic [OpW-1:0] {
    OpExit    = 3'd0,
    OpPrint   = 3'd1,
    OpInc     = 3'd2,
    OpMul     = 3'd3,
    OpMov     = 3'd4,
    OpCmp     = 3'd5,
    OpBlt     = 3'd6,
    OpIllegal = 3'd7
  } opcode_e;

  typedef logic [NibW-1:0] nib_t;
  typedef logic [PcW-1:0]  pc_t;

endpackage

// File: hw/rtl/nibble_cpu_execute_step_top.sv
// Execute stage of a small nibble CPU.
//
// Requests arrive on the input channel (in_valid_i / in_ready_o). Each request
// carries one fetched instruction: an opcode and the two program nibbles that
// follow it. Every request gives exactly one result on the output channel
// (out_valid_o / out_ready_i): the next fetch address, an optional print event
// (r0, r1 and the joined r2:r3) and the halted and fault status bits.
//
// A request is first captured in an input register. Once the output register is
// free or being emptied, it is executed against the register file, program counter
// and flags, which are updated at that edge, and its result is loaded into the
// output register. A new request can be accepted in every cycle while the receiver
// does not stall, so throughput is one instruction per cycle. The rate is set by the
// single execute step, which holds a 4x4 multiplier and the program counter adder.
//
// When the receiver stalls, the result is held in the output register and the
// request waiting in the input register stays there, unexecuted, until the
// result has been taken. Reset empties both stages and clears all four
// registers, the program counter, the compare flag and the halt flag.
module nibble_cpu_execute_step_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [2:0]       opcode_i,
  input  logic [3:0]       arg_a_i,
  input  logic [3:0]       arg_b_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output nce_pkg::pc_t     next_pc_o,
  output logic             print_valid_o,
  output nce_pkg::nib_t    print_left_o,
  output nce_pkg::nib_t    print_right_o,
  output logic [7:0]       print_product_o,
  output logic             halted_o,
  output logic             fault_o
);
  import nce_pkg::*;

  // Input register stage.
  logic           req_valid_q;
  logic [OpW-1:0] req_op_q;
  nib_t           req_a_q;
  nib_t           req_b_q;

  // Architectural state.
  nib_t rf_q [NumRegs];
  nib_t rf_d [NumRegs];
  pc_t  pc_q, pc_d;
  logic cmp_q, cmp_d;
  logic halt_q, halt_d;

  // Output register stage.
  logic       out_valid_q;
  pc_t        res_pc_q;
  logic       res_pv_q, res_pv_d;
  nib_t       res_left_q, res_left_d;
  nib_t       res_right_q, res_right_d;
  logic [7:0] res_prod_q, res_prod_d;
  logic       res_fault_q, res_fault_d;

  logic       advance;
  logic       execute;
  logic       idx_ok;
  logic [1:0] idx;
  nib_t       sel_reg;
  logic [7:0] product;
  opcode_e    op;

  // The execute stage moves on when the output register is free or is being
  // emptied in this cycle.
  assign advance    = !out_valid_q || out_ready_i;
  assign execute    = req_valid_q && advance;
  assign in_ready_o = !req_valid_q || advance;

  assign op      = opcode_e'(req_op_q);
  // Only r0 and r1 may be named by inc, mov and cmp.
  assign idx_ok  = (req_a_q[3:1] == 3'd0);
  assign idx     = {1'b0, req_a_q[0]};
  assign sel_reg = rf_q[idx];
  assign product = {4'd0, rf_q[0]} * {4'd0, rf_q[1]};

  always_comb begin
    for (int i = 0; i < NumRegs; i++) begin
      rf_d[i] = rf_q[i];
    end
    pc_d        = pc_q;
    cmp_d       = cmp_q;
    halt_d      = halt_q;
    res_pv_d    = 1'b0;
    res_left_d  = '0;
    res_right_d = '0;
    res_prod_d  = '0;
    res_fault_d = 1'b0;
    // Once halted, every later instruction is ignored.
    if (!halt_q) begin
      case (op)
        OpExit: begin
          halt_d = 1'b1;
        end
        OpPrint: begin
          res_pv_d    = 1'b1;
          res_left_d  = rf_q[0];
          res_right_d = rf_q[1];
          res_prod_d  = {rf_q[2], rf_q[3]};
          pc_d        = pc_q + 8'd1;
        end
        OpInc: begin
          if (idx_ok) begin
            rf_d[idx] = sel_reg + 4'd1;
            pc_d      = pc_q + 8'd2;
          end else begin
            res_fault_d = 1'b1;
          end
        end
        OpMul: begin
          rf_d[2] = product[7:4];
          rf_d[3] = product[3:0];
          pc_d    = pc_q + 8'd3;
        end
        OpMov: begin
          if (idx_ok) begin
            rf_d[idx] = req_b_q;
            pc_d      = pc_q + 8'd3;
          end else begin
            res_fault_d = 1'b1;
          end
        end
        OpCmp: begin
          if (idx_ok) begin
            cmp_d = (sel_reg >= req_b_q);
            pc_d  = pc_q + 8'd3;
          end else begin
            res_fault_d = 1'b1;
          end
        end
        OpBlt: begin
          // Branch is taken when the flag is clear; the flag always clears.
          if (!cmp_q) begin
            pc_d = {req_a_q, req_b_q};
          end else begin
            pc_d = pc_q + 8'd3;
          end
          cmp_d = 1'b0;
        end
        default: begin
          res_fault_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumRegs; i++) begin
        rf_q[i] <= '0;
      end
      pc_q   <= '0;
      cmp_q  <= 1'b0;
      halt_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        req_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= req_valid_q;
      end
      if (execute) begin
        for (int i = 0; i < NumRegs; i++) begin
          rf_q[i] <= rf_d[i];
        end
        pc_q   <= pc_d;
        cmp_q  <= cmp_d;
        halt_q <= halt_d;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_op_q <= opcode_i;
      req_a_q  <= arg_a_i;
      req_b_q  <= arg_b_i;
    end
    if (execute) begin
      res_pc_q    <= pc_d;
      res_pv_q    <= res_pv_d;
      res_left_q  <= res_left_d;
      res_right_q <= res_right_d;
      res_prod_q  <= res_prod_d;
      res_fault_q <= res_fault_d;
    end
  end

  // halted_o is only read alongside out_valid_o, so the held state is used.
  assign out_valid_o     = out_valid_q;
  assign next_pc_o       = res_pc_q;
  assign print_valid_o   = res_pv_q;
  assign print_left_o    = res_left_q;
  assign print_right_o   = res_right_q;
  assign print_product_o = res_prod_q;
  assign halted_o        = halt_q;
  assign fault_o         = res_fault_q;

  // Once the halt flag is set, only reset clears it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $past(halt_q) |-> halt_q)
    else $error("halt flag cleared without reset");

  // A result never reports a print and a fault together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(print_valid_o && fault_o))
    else $error("print and fault reported together");

  // State only changes when an instruction executes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(execute) |-> ($stable(pc_q) && $stable(cmp_q) && $stable(halt_q)))
    else $error("state changed without an executed instruction");

  // A stalled result stage keeps the waiting request out of execution.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !execute)
    else $error("instruction executed while result stalled");

endmodule

// File: tb/nibble_cpu_execute_step_top_tb.sv
module nibble_cpu_execute_step_top_tb;

  import nce_pkg::*;

  // One fetched instruction as the fetch stage would present it.
  typedef struct packed {
    opcode_e op;
    nib_t    arg_a;
    nib_t    arg_b;
  } instr_t;

  // Everything the execute stage reports for one instruction.
  typedef struct packed {
    pc_t        next_pc;
    logic       print_valid;
    nib_t       print_left;
    nib_t       print_right;
    logic [7:0] print_product;
    logic       halted;
    logic       fault;
  } exec_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [2:0] opcode_i = '0;
  logic [3:0] arg_a_i = '0;
  logic [3:0] arg_b_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  pc_t        next_pc_o;
  logic       print_valid_o;
  nib_t       print_left_o;
  nib_t       print_right_o;
  logic [7:0] print_product_o;
  logic       halted_o;
  logic       fault_o;

  nibble_cpu_execute_step_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .arg_a_i        (arg_a_i),
    .arg_b_i        (arg_b_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .next_pc_o      (next_pc_o),
    .print_valid_o  (print_valid_o),
    .print_left_o   (print_left_o),
    .print_right_o  (print_right_o),
    .print_product_o(print_product_o),
    .halted_o       (halted_o),
    .fault_o        (fault_o)
  );

  // Instructions waiting to be presented, and the results that accepted
  // instructions are owed, oldest first.
  instr_t       instr_q[$];
  exec_result_t exec_results_q[$];

  // The testbench's own copy of the architectural state of the CPU.
  nib_t cpu_regs[NumRegs];
  pc_t  cpu_pc;
  logic cpu_flag;
  logic cpu_halt;

  int unsigned errors      = 0;
  int unsigned n_executed  = 0;
  int unsigned n_prints    = 0;
  int unsigned n_faults    = 0;
  int unsigned n_taken     = 0;
  int unsigned n_ignored   = 0;
  int unsigned n_checked   = 0;
  int unsigned burst_left  = 0;
  int unsigned gap_left    = 0;
  int unsigned ready_cycle = 0;
  logic        req_taken   = 1'b0;

  // The clock runs freely with a period of 20 time units.
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Hard limit on the run. A correct run needs only a small fraction of it,
  // so reaching it means the block has stopped answering.
  initial begin
    #8000000;
    $display("Timeout at %0t with %0d requests and %0d results outstanding.",
             $time, instr_q.size(), exec_results_q.size());
    $display("== FAIL ==");
    $finish;
  end

  // Executes one instruction on the local copy of the state and returns what
  // the block should report for it. Once the CPU has halted every request is
  // ignored; a bad register index or an illegal opcode faults and leaves all
  // state alone.
  task automatic execute_instr(input instr_t ins, output exec_result_t res);
    logic [7:0] prod;
    logic       reg_ok;
    res    = '0;
    reg_ok = (ins.arg_a < 4'd2);
    if (cpu_halt) begin
      n_ignored++;
    end else begin
      n_executed++;
      case (ins.op)
        OpExit: begin
          cpu_halt = 1'b1;
        end
        OpPrint: begin
          res.print_valid   = 1'b1;
          res.print_left    = cpu_regs[0];
          res.print_right   = cpu_regs[1];
          res.print_product = {cpu_regs[2], cpu_regs[3]};
          cpu_pc            = cpu_pc + 8'd1;
          n_prints++;
        end
        OpInc: begin
          if (reg_ok) begin
            cpu_regs[ins.arg_a] = cpu_regs[ins.arg_a] + 4'd1;
            cpu_pc              = cpu_pc + 8'd2;
          end else begin
            res.fault = 1'b1;
          end
        end
        OpMul: begin
          prod        = {4'd0, cpu_regs[0]} * {4'd0, cpu_regs[1]};
          cpu_regs[2] = prod[7:4];
          cpu_regs[3] = prod[3:0];
          cpu_pc      = cpu_pc + 8'd3;
        end
        OpMov: begin
          if (reg_ok) begin
            cpu_regs[ins.arg_a] = ins.arg_b;
            cpu_pc              = cpu_pc + 8'd3;
          end else begin
            res.fault = 1'b1;
          end
        end
        OpCmp: begin
          if (reg_ok) begin
            cpu_flag = (cpu_regs[ins.arg_a] >= ins.arg_b);
            cpu_pc   = cpu_pc + 8'd3;
          end else begin
            res.fault = 1'b1;
          end
        end
        OpBlt: begin
          // The branch is taken when the flag is clear; a compare sets it on "not less than".
          if (!cpu_flag) begin
            cpu_pc = {ins.arg_a, ins.arg_b};
            n_taken++;
          end else begin
            cpu_pc = cpu_pc + 8'd3;
          end
          cpu_flag = 1'b0;
        end
        default: begin
          res.fault = 1'b1;
        end
      endcase
      if (res.fault) n_faults++;
    end
    res.next_pc = cpu_pc;
    res.halted  = cpu_halt;
  endtask

  task automatic report_field(input string name, input int unsigned exp_val,
                              input int unsigned act_val);
    if (exp_val != act_val) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, name, exp_val, act_val);
    end
  endtask

  task automatic queue_instr(input opcode_e op, input nib_t a, input nib_t b);
    instr_t ins;
    ins.op    = op;
    ins.arg_a = a;
    ins.arg_b = b;
    instr_q.push_back(ins);
  endtask

  // Builds random program content. Most instructions are well formed, with a
  // valid register index, and compares are often followed straight away by a
  // branch so that both outcomes of the flag are exercised. The rest is noise
  // with any opcode other than exit and any argument values.
  task automatic queue_random(input int unsigned count);
    int unsigned i;
    opcode_e     op;
    i = 0;
    while (i < count) begin
      if ($urandom_range(0, 6) == 0) begin
        op = opcode_e'($urandom_range(1, 7));
        queue_instr(op, nib_t'($urandom_range(0, 15)), nib_t'($urandom_range(0, 15)));
        i++;
      end else if ($urandom_range(0, 5) == 0) begin
        queue_instr(OpCmp, nib_t'($urandom_range(0, 1)), nib_t'($urandom_range(0, 15)));
        queue_instr(OpBlt, nib_t'($urandom_range(0, 15)), nib_t'($urandom_range(0, 15)));
        i += 2;
      end else begin
        op = opcode_e'($urandom_range(1, 6));
        if (op inside {OpInc, OpMov, OpCmp}) begin
          queue_instr(op, nib_t'($urandom_range(0, 1)), nib_t'($urandom_range(0, 15)));
        end else begin
          queue_instr(op, nib_t'($urandom_range(0, 15)), nib_t'($urandom_range(0, 15)));
        end
        i++;
      end
    end
  endtask

  // Waits until every queued request has been accepted and every result has
  // been returned. Sampled on the falling edge, away from the monitor.
  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (instr_q.size() != 0 || in_valid_i || exec_results_q.size() != 0);
  endtask

  // Sender. Requests go out in bursts of random length separated by random
  // gaps; some bursts follow one another with no gap at all. A request that
  // has been raised is held, unchanged, until the monitor saw it accepted.
  always @(negedge clk_i) begin
    instr_t ins;
    logic   drive;
    drive = 1'b0;
    if (rst_ni && !(in_valid_i && !req_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (instr_q.size() > 0) begin
        ins      = instr_q.pop_front();
        drive    = 1'b1;
        opcode_i <= ins.op;
        arg_a_i  <= ins.arg_a;
        arg_b_i  <= ins.arg_b;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
      in_valid_i <= drive;
    end
  end

  // Receiver. Its stall pattern moves in turn through four modes: always
  // ready, ready at random half the time, mostly ready, and a fixed
  // rhythm of short ready windows and longer stalls.
  always @(negedge clk_i) begin
    logic rdy;
    ready_cycle++;
    case ((ready_cycle / 300) % 4)
      0:       rdy = 1'b1;
      1:       rdy = 1'($urandom_range(0, 1));
      2:       rdy = ($urandom_range(0, 3) != 0);
      default: rdy = ((ready_cycle % 7) < 3);
    endcase
    if (rst_ni) begin
      out_ready_i <= rdy;
    end
  end

  // Monitor. Results are checked first and then any newly accepted request
  // is executed on the local state. A request passes the input and output
  // registers, so no result belongs to the request accepted at the same edge.
  always @(posedge clk_i) begin
    exec_result_t exp_res;
    exec_result_t new_res;
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (exec_results_q.size() == 0) begin
          errors++;
          $display("%0t: result with next_pc 0x%0h arrived with none expected",
                   $time, next_pc_o);
        end else begin
          exp_res = exec_results_q.pop_front();
          n_checked++;
          report_field("next_pc", exp_res.next_pc, next_pc_o);
          report_field("print_valid", exp_res.print_valid, print_valid_o);
          report_field("print_left", exp_res.print_left, print_left_o);
          report_field("print_right", exp_res.print_right, print_right_o);
          report_field("print_product", exp_res.print_product, print_product_o);
          report_field("halted", exp_res.halted, halted_o);
          report_field("fault", exp_res.fault, fault_o);
        end
      end
      if (in_valid_i && in_ready_o) begin
        execute_instr(instr_t'({opcode_i, arg_a_i, arg_b_i}), new_res);
        exec_results_q.push_back(new_res);
        req_taken <= 1'b1;
      end else begin
        req_taken <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned k;
    for (k = 0; k < NumRegs; k++) cpu_regs[k] = '0;
    cpu_pc   = '0;
    cpu_flag = 1'b0;
    cpu_halt = 1'b0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed opening: largest operands and the widest product, register
    // wrap-around, unused arguments, bad register indices for every
    // instruction that takes one, illegal opcodes, both branch outcomes and
    // program counter wrap-around.
    queue_instr(OpMov, 4'd0, 4'd15);
    queue_instr(OpMov, 4'd1, 4'd15);
    queue_instr(OpMul, 4'd5, 4'd10);
    queue_instr(OpPrint, 4'd15, 4'd15);
    queue_instr(OpInc, 4'd0, 4'd15);
    queue_instr(OpInc, 4'd1, 4'd0);
    queue_instr(OpPrint, 4'd0, 4'd0);
    queue_instr(OpMov, 4'd2, 4'd15);
    queue_instr(OpInc, 4'd15, 4'd0);
    queue_instr(OpCmp, 4'd8, 4'd0);
    queue_instr(OpIllegal, 4'd15, 4'd15);
    queue_instr(OpIllegal, 4'd0, 4'd0);
    queue_instr(OpCmp, 4'd0, 4'd0);
    queue_instr(OpBlt, 4'd15, 4'd15);
    queue_instr(OpCmp, 4'd1, 4'd15);
    queue_instr(OpBlt, 4'd15, 4'd15);
    queue_instr(OpInc, 4'd0, 4'd3);
    queue_instr(OpCmp, 4'd0, 4'd1);
    queue_instr(OpBlt, 4'd0, 4'd0);
    queue_instr(OpBlt, 4'd0, 4'd0);
    queue_instr(OpMov, 4'd1, 4'd0);
    queue_instr(OpMul, 4'd15, 4'd0);
    queue_instr(OpPrint, 4'd9, 4'd6);

    // The test queues nothing more here until everything in flight has returned.
    wait_drained();

    queue_random(440);
    wait_drained();
    queue_random(440);

    // Exit last of all, since a halted CPU never runs again. What follows it
    // must all be ignored, a second exit and an illegal opcode among them.
    queue_instr(OpExit, nib_t'($urandom_range(0, 15)), nib_t'($urandom_range(0, 15)));
    queue_instr(OpPrint, 4'd0, 4'd0);
    queue_instr(OpInc, 4'd0, 4'd0);
    queue_instr(OpExit, 4'd15, 4'd15);
    queue_instr(OpIllegal, 4'd3, 4'd3);
    queue_instr(OpMov, 4'd5, 4'd7);
    queue_instr(OpBlt, 4'd0, 4'd0);
    queue_instr(OpMul, 4'd1, 4'd1);

    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("Ran %0d instructions and ignored %0d after exit: %0d prints, %0d faults,",
             n_executed, n_ignored, n_prints, n_faults);
    $display("%0d taken branches; %0d results compared, %0d mismatches.",
             n_taken, n_checked, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/nce_pkg.sv
hw/rtl/nibble_cpu_execute_step_top.sv
tb/nibble_cpu_execute_step_top_tb.sv
